/* design/sfs_pkg.sv */
// Types and constants shared by the screen fade sequencer.
package sfs_pkg;

  // Fade phases, one-hot
  typedef enum logic [5:0] {
    PH_FADED_IN   = 6'b000001,
    PH_PAUSE_IN   = 6'b000010,
    PH_FADING_IN  = 6'b000100,
    PH_FADING_OUT = 6'b001000,
    PH_PAUSE_OUT  = 6'b010000,
    PH_FADED_OUT  = 6'b100000
  } phase_t;

  // Phase numbers as reported on the result beat
  localparam logic [2:0] PHN_FADED_IN   = 3'd0;
  localparam logic [2:0] PHN_PAUSE_IN   = 3'd1;
  localparam logic [2:0] PHN_FADING_IN  = 3'd2;
  localparam logic [2:0] PHN_FADING_OUT = 3'd3;
  localparam logic [2:0] PHN_PAUSE_OUT  = 3'd4;
  localparam logic [2:0] PHN_FADED_OUT  = 3'd5;

  // Command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_FADE_OUT = 2'd1;
  localparam logic [1:0] CMD_FADE_IN  = 2'd2;

  // Overlay kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_SUB    = 2'd2;
  localparam logic [1:0] KIND_OPAQUE = 2'd3;

  // Register indexes
  localparam logic REG_LEVEL_STEP = 1'b0;
  localparam logic REG_WAIT_TICKS = 1'b1;

  localparam logic [7:0] FULL_LEVEL       = 8'd255;
  localparam logic [7:0] LEVEL_STEP_RESET = 8'd8;
  localparam logic [7:0] WAIT_TICKS_RESET = 8'd30;

  // Result beat layout
  typedef struct packed {
    logic       pad;
    logic [2:0] phase_out;
    logic       busy_res;
    logic       volume_update;
    logic [7:0] volume;
    logic [7:0] overlay_level;
    logic [1:0] overlay_kind;
  } result_t;

  // One-hot phase to its number
  function automatic logic [2:0] phase_num(input phase_t ph);
    logic [2:0] n;
    n = PHN_FADED_IN;
    unique case (ph)
      PH_FADED_IN:   n = PHN_FADED_IN;
      PH_PAUSE_IN:   n = PHN_PAUSE_IN;
      PH_FADING_IN:  n = PHN_FADING_IN;
      PH_FADING_OUT: n = PHN_FADING_OUT;
      PH_PAUSE_OUT:  n = PHN_PAUSE_OUT;
      PH_FADED_OUT:  n = PHN_FADED_OUT;
      default:       n = PHN_FADED_IN;
    endcase
    return n;
  endfunction

endpackage

/* design/screen_fade_sequencer.sv */
// Screen fade sequencer: phase state, level and pause counters, result register.
//
//  Channel | Direction | Content
//  s_axis  | in        | tuser: command; tdata: style, frames
//  m_axis  | out       | tdata: overlay kind/level, volume, update, busy, phase
//  cfg     | in        | write enable, register index, 8-bit data
//
// One beat per cycle while the output is not stalled: the command is applied to the phase,
// level and pause registers and the result is captured in the output register on the same edge.
// The arithmetic is a 4x8 multiply, a 12-bit compare, an 8-bit subtract and an 8-bit decrement.
// A new beat is taken whenever the output register is empty or being drained.
// rst (synchronous) returns the phase to faded in and the registers to defaults.
module screen_fade_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] style, [4:1] frames, [7:5] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] overlay_kind, [9:2] overlay_level,
                                      // [17:10] volume, [18] volume_update,
                                      // [19] busy_res, [22:20] phase_out, [23] zero
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data
);

  sfs_pkg::phase_t phase, phase_next;
  logic [7:0]  level, level_next;
  logic [7:0]  pause_count, pause_count_next;
  logic        white_style, white_style_next;
  logic [7:0]  level_step, wait_ticks;

  logic        in_beat;
  logic [1:0]  command;
  logic        style;
  logic [3:0]  frames;
  logic [11:0] dec;
  logic [7:0]  volume;
  logic        vol_upd;
  logic [1:0]  kind;
  logic [7:0]  olevel;
  logic        busy;
  sfs_pkg::result_t res;

  assign command = s_axis_tuser;
  assign style   = s_axis_tdata[0];
  assign frames  = s_axis_tdata[4:1];

  // take a beat when the result register is free or emptying
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign dec = {8'd0, frames} * {4'd0, level_step};

  // state update
  always_comb begin
    phase_next       = phase;
    level_next       = level;
    pause_count_next = pause_count;
    white_style_next = white_style;
    volume           = 8'd0;
    vol_upd          = 1'b0;
    unique case (command)
      sfs_pkg::CMD_FADE_OUT, sfs_pkg::CMD_FADE_IN: begin
        level_next       = sfs_pkg::FULL_LEVEL;
        white_style_next = style;
        pause_count_next = wait_ticks;
        phase_next       = (command == sfs_pkg::CMD_FADE_OUT) ?
                           sfs_pkg::PH_FADING_OUT : sfs_pkg::PH_PAUSE_IN;
      end
      sfs_pkg::CMD_TICK: begin
        unique case (phase)
          sfs_pkg::PH_FADING_IN, sfs_pkg::PH_FADING_OUT: begin
            vol_upd = 1'b1;
            if (dec > {4'd0, level}) begin
              // fade ends: clamp and move on
              level_next = 8'd0;
              if (phase == sfs_pkg::PH_FADING_OUT) begin
                pause_count_next = wait_ticks;
                phase_next       = sfs_pkg::PH_PAUSE_OUT;
                volume           = 8'd0;
              end else begin
                phase_next = sfs_pkg::PH_FADED_IN;
                volume     = sfs_pkg::FULL_LEVEL;
              end
            end else begin
              level_next = level - dec[7:0];
              volume     = (phase == sfs_pkg::PH_FADING_OUT) ? level_next : ~level_next;
            end
          end
          sfs_pkg::PH_PAUSE_IN, sfs_pkg::PH_PAUSE_OUT: begin
            pause_count_next = pause_count - 8'd1;
            if (pause_count_next == 8'd0) begin
              phase_next = (phase == sfs_pkg::PH_PAUSE_IN) ?
                           sfs_pkg::PH_FADING_IN : sfs_pkg::PH_FADED_OUT;
            end
          end
          default: ;
        endcase
      end
      default: ;  // unused command: state holds
    endcase
  end

  // overlay from the updated state
  always_comb begin
    kind   = sfs_pkg::KIND_NONE;
    olevel = 8'd0;
    busy   = 1'b0;
    unique case (phase_next)
      sfs_pkg::PH_PAUSE_IN, sfs_pkg::PH_FADING_IN: begin
        kind   = white_style_next ? sfs_pkg::KIND_ADD : sfs_pkg::KIND_SUB;
        olevel = level_next;
        busy   = 1'b1;
      end
      sfs_pkg::PH_FADING_OUT, sfs_pkg::PH_PAUSE_OUT: begin
        kind   = white_style_next ? sfs_pkg::KIND_ADD : sfs_pkg::KIND_SUB;
        olevel = ~level_next;
        busy   = 1'b1;
      end
      sfs_pkg::PH_FADED_OUT: begin
        kind   = sfs_pkg::KIND_OPAQUE;
        olevel = white_style_next ? sfs_pkg::FULL_LEVEL : 8'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.pad           = 1'b0;
    res.phase_out     = sfs_pkg::phase_num(phase_next);
    res.busy_res      = busy;
    res.volume_update = vol_upd;
    res.volume        = volume;
    res.overlay_level = olevel;
    res.overlay_kind  = kind;
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sfs_pkg::PH_FADED_IN;
      level       <= 8'd0;
      pause_count <= 8'd0;
      white_style <= 1'b0;
      level_step  <= sfs_pkg::LEVEL_STEP_RESET;
      wait_ticks  <= sfs_pkg::WAIT_TICKS_RESET;
    end else begin
      if (in_beat) begin
        phase       <= phase_next;
        level       <= level_next;
        pause_count <= pause_count_next;
        white_style <= white_style_next;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          sfs_pkg::REG_LEVEL_STEP: level_step <= cfg_data;
          sfs_pkg::REG_WAIT_TICKS: wait_ticks <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_axis_tdata <= res;
    end
  end

endmodule
